@@ design/tgarle_pkg.sv @@
// Package: shared types and constants of the TGA run-length pixel decoder.
package tgarle_pkg;

  // Configuration port widths
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 16;

  // Register map of the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    RegImageType  = 4'd0,
    RegPixelDepth = 4'd1,
    RegImageWidth = 4'd2,
    RegImageHeight = 4'd3
  } cfg_reg_e;

  // Supported image type codes and depths
  localparam logic [7:0] TypeRawTrue = 8'd2;
  localparam logic [7:0] TypeRleTrue = 8'd10;
  localparam logic [7:0] Depth24     = 8'd24;
  localparam logic [7:0] Depth32     = 8'd32;

  // Packet header: bit 7 flags a run, low bits hold count minus one
  localparam int unsigned RunBit = 7;

  // Reset values of the configuration registers
  localparam logic [7:0]  ImageTypeRst  = TypeRleTrue;
  localparam logic [7:0]  PixelDepthRst = Depth24;

  // Configuration as seen by the decode stage
  typedef struct packed {
    logic [7:0]  image_type;
    logic [7:0]  pixel_depth;
    logic [31:0] pixel_total;
  } cfg_t;

endpackage

@@ design/tgarle_if.sv @@
// Interfaces: byte input, pixel result and configuration write channels.
interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface tgarle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] repeat_count;
  logic       last_pixel;
  logic       format_error;

  modport source (output valid, red, green, blue, repeat_count, last_pixel, format_error,
                  input ready);
  modport sink   (input valid, red, green, blue, repeat_count, last_pixel, format_error,
                  output ready);
endinterface

interface tgarle_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tgarle_pkg::CfgAddrW-1:0] addr;
  logic [tgarle_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

@@ design/tgarle_cfg.sv @@
// Configuration registers and the registered pixel total.
module tgarle_cfg
  import tgarle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  logic [CfgAddrW-1:0] wr_addr_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  logic [7:0]  image_type_q;
  logic [7:0]  pixel_depth_q;
  logic [15:0] image_width_q;
  logic [15:0] image_height_q;
  logic [31:0] total_q;

  // Accept every write request at once
  assign wr_ready_o = 1'b1;

  // Update the addressed register; ignore addresses past the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_type_q   <= ImageTypeRst;
      pixel_depth_q  <= PixelDepthRst;
      image_width_q  <= '0;
      image_height_q <= '0;
    end else if (wr_valid_i) begin
      case (cfg_reg_e'(wr_addr_i))
        RegImageType:   image_type_q   <= wr_data_i[7:0];
        RegPixelDepth:  pixel_depth_q  <= wr_data_i[7:0];
        RegImageWidth:  image_width_q  <= wr_data_i[15:0];
        RegImageHeight: image_height_q <= wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Register the width by height product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= {16'd0, image_width_q} * {16'd0, image_height_q};
    end
  end

  assign cfg_o.image_type  = image_type_q;
  assign cfg_o.pixel_depth = pixel_depth_q;
  assign cfg_o.pixel_total = total_q;

endmodule

@@ design/tgarle_decode.sv @@
// Decode stage: input register, packet and pixel state, result register.
module tgarle_decode
  import tgarle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_count_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // Decoder state
  logic [23:0] pixel_bytes_q, pixel_bytes_d;
  logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
  logic        expect_header_q, expect_header_d;
  logic        packet_is_run_q, packet_is_run_d;
  logic [7:0]  packet_remaining_q, packet_remaining_d;
  logic [31:0] pixels_done_q, pixels_done_d;
  logic        frame_finished_q, frame_finished_d;

  // Result register
  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q, count_q;
  logic       last_q, error_q;

  // Result of the current byte
  logic       res_valid;
  logic [7:0] res_red, res_green, res_blue, res_count;
  logic       res_last, res_error;

  logic advance;
  logic fire;

  // Move the input register on whenever the result register can take a request
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign fire       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= in_byte_i;
      s1_start_q <= in_start_i;
    end
  end

  // Decode one byte against the packet and pixel state
  always_comb begin
    logic        is_rle;
    logic        fmt_ok;
    logic [32:0] diff;
    logic        at_end;
    logic [31:0] left;
    logic        left_small;
    logic [7:0]  count_raw;
    logic        clip;
    logic        hit_total;
    logic [2:0]  bytes_per_pixel;

    is_rle          = cfg_i.image_type == TypeRleTrue;
    fmt_ok          = (cfg_i.image_type == TypeRawTrue || is_rle)
                      && (cfg_i.pixel_depth == Depth24 || cfg_i.pixel_depth == Depth32);
    bytes_per_pixel = (cfg_i.pixel_depth == Depth32) ? 3'd4 : 3'd3;

    // Start from the stored state, or from a fresh frame
    if (s1_start_q) begin
      pixel_bytes_d      = '0;
      byte_in_pixel_d    = '0;
      expect_header_d    = 1'b1;
      packet_is_run_d    = 1'b0;
      packet_remaining_d = '0;
      pixels_done_d      = '0;
      frame_finished_d   = 1'b0;
    end else begin
      pixel_bytes_d      = pixel_bytes_q;
      byte_in_pixel_d    = byte_in_pixel_q;
      expect_header_d    = expect_header_q;
      packet_is_run_d    = packet_is_run_q;
      packet_remaining_d = packet_remaining_q;
      pixels_done_d      = pixels_done_q;
      frame_finished_d   = frame_finished_q;
    end

    diff       = {1'b0, cfg_i.pixel_total} - {1'b0, pixels_done_d};
    at_end     = diff[32] || (diff[31:0] == '0);
    left       = diff[31:0];
    left_small = left[31:8] == '0;

    res_valid = 1'b0;
    res_red   = '0;
    res_green = '0;
    res_blue  = '0;
    res_count = '0;
    res_last  = 1'b0;
    res_error = 1'b0;
    count_raw = 8'd1;
    clip      = 1'b0;
    hit_total = 1'b0;

    if (frame_finished_d) begin
      // Drop bytes until the next frame start
    end else if (!fmt_ok) begin
      res_valid        = 1'b1;
      res_last         = 1'b1;
      res_error        = 1'b1;
      frame_finished_d = 1'b1;
    end else if (at_end) begin
      frame_finished_d = 1'b1;
    end else if (is_rle && expect_header_d) begin
      packet_is_run_d    = s1_byte_q[RunBit];
      packet_remaining_d = {1'b0, s1_byte_q[RunBit-1:0]} + 8'd1;
      expect_header_d    = 1'b0;
      byte_in_pixel_d    = '0;
    end else begin
      // Collect the stored B, G, R bytes; alpha is dropped
      if (byte_in_pixel_d == 2'd0) begin
        pixel_bytes_d = '0;
      end
      case (byte_in_pixel_d)
        2'd0:    pixel_bytes_d[7:0]   = s1_byte_q;
        2'd1:    pixel_bytes_d[15:8]  = s1_byte_q;
        2'd2:    pixel_bytes_d[23:16] = s1_byte_q;
        default: ;
      endcase

      if ({1'b0, byte_in_pixel_d} + 3'd1 < bytes_per_pixel) begin
        byte_in_pixel_d = byte_in_pixel_d + 2'd1;
      end else begin
        byte_in_pixel_d = '0;

        if (is_rle && packet_is_run_d && packet_remaining_d != '0) begin
          count_raw = packet_remaining_d;
        end
        // Clip against the pixels left in the image
        clip      = left_small && (left[7:0] < count_raw);
        hit_total = clip || (left_small && (left[7:0] == count_raw));
        res_count = clip ? left[7:0] : count_raw;
        pixels_done_d = hit_total ? cfg_i.pixel_total
                                  : pixels_done_d + {24'd0, count_raw};

        if (is_rle) begin
          if (packet_is_run_d) begin
            packet_remaining_d = '0;
          end else if (packet_remaining_d != '0) begin
            packet_remaining_d = packet_remaining_d - 8'd1;
          end
          if (packet_remaining_d == '0) begin
            expect_header_d = 1'b1;
          end
        end

        res_valid = 1'b1;
        res_red   = pixel_bytes_d[23:16];
        res_green = pixel_bytes_d[15:8];
        res_blue  = pixel_bytes_d[7:0];
        res_last  = hit_total;
        if (hit_total) begin
          frame_finished_d = 1'b1;
        end
      end
    end
  end

  // Hold decoder state; advance it once per decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bytes_q      <= '0;
      byte_in_pixel_q    <= '0;
      expect_header_q    <= 1'b1;
      packet_is_run_q    <= 1'b0;
      packet_remaining_q <= '0;
      pixels_done_q      <= '0;
      frame_finished_q   <= 1'b0;
    end else if (fire) begin
      pixel_bytes_q      <= pixel_bytes_d;
      byte_in_pixel_q    <= byte_in_pixel_d;
      expect_header_q    <= expect_header_d;
      packet_is_run_q    <= packet_is_run_d;
      packet_remaining_q <= packet_remaining_d;
      pixels_done_q      <= pixels_done_d;
      frame_finished_q   <= frame_finished_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      red_q   <= res_red;
      green_q <= res_green;
      blue_q  <= res_blue;
      count_q <= res_count;
      last_q  <= res_last;
      error_q <= res_error;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_count_o = count_q;
  assign out_last_o  = last_q;
  assign out_error_o = error_q;

endmodule

@@ design/tga_rle_pixel_decoder.sv @@
// TGA pixel data decoder for raw (type 2) and run-length (type 10) truecolor images at
// 24 or 32 bits per pixel. One data byte is taken per cycle; a request is held in an
// input register and decoded into a result register, and the sustained rate is one
// byte per clock as long as results are taken. A result is one pixel or one whole run
// (repeat_count up to 128), clipped at width times height; an unsupported type or
// depth gives a single error result per frame. Configuration writes take effect once
// the registers update; width and height reach the pixel total through a further
// product register. There is no clearing pass.
module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  tgarle_in_if.sink    in_i,
  tgarle_out_if.source out_o,
  tgarle_cfg_if.sink   cfg_i
);

  cfg_t cfg;

  // Configuration registers
  tgarle_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_addr_i  (cfg_i.addr),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  // Byte decoder
  tgarle_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_byte_i   (in_i.data_byte),
    .in_start_i  (in_i.frame_start),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_red_o   (out_o.red),
    .out_green_o (out_o.green),
    .out_blue_o  (out_o.blue),
    .out_count_o (out_o.repeat_count),
    .out_last_o  (out_o.last_pixel),
    .out_error_o (out_o.format_error)
  );

endmodule

@@ design/tgarle_checker.sv @@
// Checker: port-level properties of the decoder, bound to the top level.
module tgarle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] count_i,
  input logic       last_i,
  input logic       error_i
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(count_i) && $stable(red_i) && $stable(last_i))
    else $error("stalled result changed");

  // An error result is blank and ends the frame
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i |-> last_i && count_i == 8'd0 && red_i == 8'd0
                               && green_i == 8'd0 && blue_i == 8'd0)
    else $error("error result not blank");

  // A pixel result covers one to 128 pixels
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !error_i |-> count_i != 8'd0 && count_i <= 8'd128)
    else $error("repeat count out of range");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red),
  .green_i     (out_o.green),
  .blue_i      (out_o.blue),
  .count_i     (out_o.repeat_count),
  .last_i      (out_o.last_pixel),
  .error_i     (out_o.format_error)
);
